// ----- rtl/crtc_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// crtc_pkg
// shared register codes, time register selector and decode helper
// ---------------------------------------------------------------------------
package crtc_pkg;

	localparam int IDX_W  = 7;
	localparam int BYTE_W = 8;
	localparam int NMI_POS = 7;

	// register indexes
	localparam logic [IDX_W-1:0] REG_SECONDS = 7'h00;
	localparam logic [IDX_W-1:0] REG_MINUTES = 7'h02;
	localparam logic [IDX_W-1:0] REG_HOURS   = 7'h04;
	localparam logic [IDX_W-1:0] REG_WEEKDAY = 7'h06;
	localparam logic [IDX_W-1:0] REG_MDAY    = 7'h07;
	localparam logic [IDX_W-1:0] REG_MONTH   = 7'h08;
	localparam logic [IDX_W-1:0] REG_YEAR    = 7'h09;
	localparam logic [IDX_W-1:0] REG_C       = 7'h0C;
	localparam logic [IDX_W-1:0] REG_D       = 7'h0D;
	localparam logic [IDX_W-1:0] REG_CENTURY = 7'h32;

	// valid ram and time bit held in register d after reset
	localparam logic [BYTE_W-1:0] REG_D_VRT = 8'h80;

	// access kind bits
	localparam logic CMD_READ  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;
	localparam logic PORT_INDEX = 1'b0;
	localparam logic PORT_DATA  = 1'b1;

	typedef enum logic [3:0] {
		TSEL_NONE,
		TSEL_SECONDS,
		TSEL_MINUTES,
		TSEL_HOURS,
		TSEL_WEEKDAY,
		TSEL_MDAY,
		TSEL_MONTH,
		TSEL_YEAR,
		TSEL_CENTURY
	} time_sel_t;

	// per transaction control carried down the pipe
	typedef struct packed {
		logic rd;       // data port read
		logic nmi;      // nmi disable flag after this transaction
		logic is_time;  // index selects a time register
		logic in_range; // index falls inside the ram
	} ctl_t;

	function automatic time_sel_t time_sel(input logic [IDX_W-1:0] idx);
		time_sel_t s;
		s = TSEL_NONE;
		if (idx == REG_SECONDS) s = TSEL_SECONDS;
		if (idx == REG_MINUTES) s = TSEL_MINUTES;
		if (idx == REG_HOURS)   s = TSEL_HOURS;
		if (idx == REG_WEEKDAY) s = TSEL_WEEKDAY;
		if (idx == REG_MDAY)    s = TSEL_MDAY;
		if (idx == REG_MONTH)   s = TSEL_MONTH;
		if (idx == REG_YEAR)    s = TSEL_YEAR;
		if (idx == REG_CENTURY) s = TSEL_CENTURY;
		return s;
	endfunction

endpackage

// ----- rtl/crtc_ram.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// crtc_ram
// cmos byte ram, one write and one registered read port, per-entry valid
// bits stand in for the reset contents
// ---------------------------------------------------------------------------
module crtc_ram #(
	parameter int DEPTH = 128,
	parameter int AW    = 7
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [crtc_pkg::BYTE_W-1:0] wdata,
	input  logic                      re,
	input  logic [AW-1:0]             raddr,
	output logic [crtc_pkg::BYTE_W-1:0] rdata
);
	import crtc_pkg::*;

	logic [BYTE_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]  vld_q;
	logic [BYTE_W-1:0] mem_rd_q;
	logic              vld_rd_q;
	logic              isd_rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (we) begin
			vld_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			mem_rd_q <= mem[raddr];
			vld_rd_q <= vld_q[raddr];
			isd_rd_q <= (raddr == REG_D[AW-1:0]);
		end
	end

	// never written entries read as their reset value
	assign rdata = vld_rd_q ? mem_rd_q : (isd_rd_q ? REG_D_VRT : '0);

endmodule

// ----- rtl/crtc_time.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// crtc_time
// time register path: field select, year split by 100, binary to bcd
// ---------------------------------------------------------------------------
module crtc_time (
	input  logic                        clk,
	input  logic                        ld_s1,
	input  logic                        ld_s2,
	input  crtc_pkg::time_sel_t         sel,
	input  logic [5:0]                  seconds,
	input  logic [5:0]                  minutes,
	input  logic [4:0]                  hours,
	input  logic [2:0]                  weekday,
	input  logic [4:0]                  mday,
	input  logic [3:0]                  month,
	input  logic [13:0]                 year,
	output logic [crtc_pkg::BYTE_W-1:0] bcd
);
	import crtc_pkg::*;

	// year / 100 as (year * 5243) >> 19, exact for any 14 bit year
	localparam logic [12:0] RECIP_100 = 13'd5243;
	localparam int          RECIP_SH  = 19;
	// v / 10 as (v * 205) >> 11, exact for any 8 bit v
	localparam logic [7:0]  RECIP_10  = 8'd205;
	localparam int          TEN_SH    = 11;

	logic [26:0]       yq_prod;
	logic [5:0]        small_val;
	time_sel_t         sel_s1;
	logic [7:0]        cent_s1;
	logic [13:0]       year_s1;
	logic [5:0]        small_s1;
	logic [13:0]       yr_rem;
	logic [7:0]        val_s2;
	logic [15:0]       tq_prod;
	logic [3:0]        tens;
	logic [7:0]        ones;

	assign yq_prod = 27'(year) * 27'(RECIP_100);

	always_comb begin
		unique case (sel)
			TSEL_SECONDS: small_val = seconds;
			TSEL_MINUTES: small_val = minutes;
			TSEL_HOURS:   small_val = 6'(hours);
			TSEL_WEEKDAY: small_val = 6'(weekday) + 6'd1;
			TSEL_MDAY:    small_val = 6'(mday);
			TSEL_MONTH:   small_val = 6'(month) + 6'd1;
			default:      small_val = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ld_s1) begin
			sel_s1   <= sel;
			cent_s1  <= yq_prod[RECIP_SH +: 8];
			year_s1  <= year;
			small_s1 <= small_val;
		end
	end

	assign yr_rem = year_s1 - 14'(cent_s1) * 14'd100;

	always_ff @(posedge clk) begin
		if (ld_s2) begin
			unique case (sel_s1)
				TSEL_CENTURY: val_s2 <= cent_s1;
				TSEL_YEAR:    val_s2 <= {1'b0, yr_rem[6:0]};
				default:      val_s2 <= {2'b00, small_s1};
			endcase
		end
	end

	assign tq_prod = 16'(val_s2) * 16'(RECIP_10);
	assign tens    = tq_prod[TEN_SH +: 4];
	assign ones    = val_s2 - 8'(tq_prod[TEN_SH +: 5]) * 8'd10;
	// tens above 15 wrap, as the byte is truncated
	assign bcd     = {tens, ones[3:0]};

endmodule

// ----- rtl/cmos_rtc_register_file_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cmos_rtc_register_file_top
// cmos real time clock register file behind an index port and a data port
// ---------------------------------------------------------------------------
//  channel | dir | tdata                               | tuser
//  s_*     | in  | one bus access plus the current time | command, port
//  m_*     | out | read byte                            | read_valid, nmi_mask
//
//  one transaction per cycle unless m_* stalls; results pass s1, s2 and the m_* register,
//  a path set by the registered ram read and the two stage time conversion
//  reset leaves the ram reading as zero with register d = 0x80, through
//  per-entry valid bits, so no clearing pass and no wait after reset
//  a stall on m_* freezes the whole pipe and drops s_tready
// ---------------------------------------------------------------------------
module cmos_rtc_register_file_top #(
	parameter int RAM_DEPTH = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,  // write_data, now_seconds, now_minutes, now_hours,
	                              // now_weekday, now_day, now_month, now_year, zero pad
	input  logic [1:0]  s_tuser,  // command, port
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // read_data
	output logic [1:0]  m_tuser   // read_valid, nmi_mask
);
	import crtc_pkg::*;

	localparam int AW = $clog2(RAM_DEPTH);

	// input unpack
	logic              cmd;
	logic              prt;
	logic [7:0]        wr_data;
	logic [5:0]        now_seconds;
	logic [5:0]        now_minutes;
	logic [4:0]        now_hours;
	logic [2:0]        now_weekday;
	logic [4:0]        now_day;
	logic [3:0]        now_month;
	logic [13:0]       now_year;

	assign cmd         = s_tuser[0];
	assign prt         = s_tuser[1];
	assign wr_data     = s_tdata[7:0];
	assign now_seconds = s_tdata[13:8];
	assign now_minutes = s_tdata[19:14];
	assign now_hours   = s_tdata[24:20];
	assign now_weekday = s_tdata[27:25];
	assign now_day     = s_tdata[32:28];
	assign now_month   = s_tdata[36:33];
	assign now_year    = s_tdata[50:37];

	// architectural state outside the ram
	logic [IDX_W-1:0]  idx_q;
	logic              nmi_q;

	// pipe control
	logic              adv;
	logic              acc;
	logic              v_s1;
	logic              v_s2;
	logic              m_valid_q;
	ctl_t              ctl_s1;
	ctl_t              ctl_s2;
	ctl_t              ctl_now;
	logic [7:0]        ram_byte_s2;
	logic [7:0]        m_data_q;
	logic [1:0]        m_user_q;

	logic              is_idx_wr;
	logic              in_range;
	logic              ram_we;
	time_sel_t         tsel;
	logic [7:0]        ram_rdata;
	logic [7:0]        bcd;

	assign adv      = !m_valid_q || m_tready;
	assign s_tready = adv;
	assign acc      = s_tvalid && adv;

	assign is_idx_wr = (cmd == CMD_WRITE) && (prt == PORT_INDEX);
	assign in_range  = {1'b0, idx_q} < 8'(RAM_DEPTH);
	assign tsel      = time_sel(idx_q);

	// c and d are read only, indexes past the ram drop the write
	assign ram_we = acc && (cmd == CMD_WRITE) && (prt == PORT_DATA) && in_range &&
	                (idx_q != REG_C) && (idx_q != REG_D);

	always_comb begin
		ctl_now.rd       = (cmd == CMD_READ) && (prt == PORT_DATA);
		ctl_now.nmi      = is_idx_wr ? wr_data[NMI_POS] : nmi_q;
		ctl_now.is_time  = (tsel != TSEL_NONE);
		ctl_now.in_range = in_range;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			nmi_q <= 1'b0;
		end else if (acc && is_idx_wr) begin
			idx_q <= wr_data[IDX_W-1:0];
			nmi_q <= wr_data[NMI_POS];
		end
	end

	// valid flags of the three stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			m_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1      <= acc;
			v_s2      <= v_s1;
			m_valid_q <= v_s2;
		end
	end

	// ram read issued on every accepted transaction, data lands at s1
	crtc_ram #(
		.DEPTH(RAM_DEPTH),
		.AW   (AW)
	) u_ram (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (ram_we),
		.waddr (idx_q[AW-1:0]),
		.wdata (wr_data),
		.re    (acc),
		.raddr (idx_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	crtc_time u_time (
		.clk    (clk),
		.ld_s1  (acc),
		.ld_s2  (adv),
		.sel    (tsel),
		.seconds(now_seconds),
		.minutes(now_minutes),
		.hours  (now_hours),
		.weekday(now_weekday),
		.mday   (now_day),
		.month  (now_month),
		.year   (now_year),
		.bcd    (bcd)
	);

	// payload stages
	always_ff @(posedge clk) begin
		if (acc) begin
			ctl_s1 <= ctl_now;
		end
		if (adv) begin
			ctl_s2      <= ctl_s1;
			ram_byte_s2 <= ram_rdata;
			m_user_q    <= {ctl_s2.nmi, ctl_s2.rd};
			priority if (!ctl_s2.rd) begin
				m_data_q <= '0;
			end else if (ctl_s2.is_time) begin
				m_data_q <= bcd;
			end else if (ctl_s2.in_range) begin
				m_data_q <= ram_byte_s2;
			end else begin
				m_data_q <= '0;
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;

	// ---------------------------------------------------------------------
	// checks
	// ---------------------------------------------------------------------
	a_no_data_unless_read: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
		else $error("result byte nonzero on a transaction that is not a data read");

	a_ro_regs: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> ((idx_q != REG_C) && (idx_q != REG_D) && in_range))
		else $error("ram write to a read only or missing register");

	a_nmi_latch: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && is_idx_wr) |=> (nmi_q == $past(wr_data[NMI_POS])))
		else $error("nmi disable flag not taken from index write");

	a_pipe_order: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (v_s2 == $past(v_s2) && v_s1 == $past(v_s1)))
		else $error("pipe moved while the result was stalled");

endmodule
